// ===== design/dust_sensor_frame_average_unit_macros.svh =====
// Assertion helpers for the file that checks the frame average unit.
`ifndef DUST_SENSOR_FRAME_AVERAGE_UNIT_MACROS_SVH
`define DUST_SENSOR_FRAME_AVERAGE_UNIT_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define DSFA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define DSFA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/dsfa_pkg.sv =====
`timescale 1ns / 1ps
package dsfa_pkg;

  // Ring geometry. The average is a shift, so the depth is a power of two.
  localparam int RING_DEPTH = 512;
  localparam int RESET_FILL = 35;
  localparam int RING_AW    = $clog2(RING_DEPTH);
  localparam int SUM_W      = 16 + RING_AW;

  localparam logic [7:0] HEADER_BYTE = 8'hAA;
  localparam logic [7:0] END_BYTE    = 8'hFF;

  // Piecewise gain in hundredths of the raw value.
  localparam int GAIN_SEGMENTS = 19;
  localparam int GAIN_W        = 12;
  localparam logic [15:0] GAIN_LIMIT [GAIN_SEGMENTS-1] = '{
    16'd1, 16'd2, 16'd3, 16'd4, 16'd6, 16'd8, 16'd10, 16'd12, 16'd15, 16'd19,
    16'd25, 16'd35, 16'd50, 16'd75, 16'd100, 16'd150, 16'd285, 16'd485
  };
  localparam logic [GAIN_W-1:0] GAIN_HUND [GAIN_SEGMENTS] = '{
    12'd3500, 12'd2000, 12'd1500, 12'd1125, 12'd1000, 12'd760, 12'd650, 12'd625,
    12'd620, 12'd562, 12'd500, 12'd488, 12'd450, 12'd329, 12'd250, 12'd167,
    12'd100, 12'd70, 12'd60
  };

  // The largest gain product is 65535 * 60, which stays below 2^22.
  localparam int PROD_W = 22;
  // Division by 100 as a multiplication: ceil(2^28 / 100). It is exact for
  // every product below 2^22 because 44 * 2^22 stays below 2^28.
  localparam int RECIP_W     = 22;
  localparam int RECIP_SHIFT = 28;
  localparam logic [RECIP_W-1:0] RECIP_100 = 22'd2684355;

  localparam int JOBQ_DEPTH = 2;
  localparam int OUTQ_DEPTH = 4;

  typedef enum logic [1:0] {
    ST_STORED = 2'd0,
    ST_BAD    = 2'd1,
    ST_ZERO   = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    FP_HUNT = 3'd0,
    FP_VHI  = 3'd1,
    FP_VLO  = 3'd2,
    FP_RHI  = 3'd3,
    FP_RLO  = 3'd4,
    FP_CSUM = 3'd5,
    FP_END  = 3'd6
  } fpos_t;

  typedef struct packed {
    status_t     status;
    logic [15:0] raw;
  } job_t;

  typedef struct packed {
    status_t     status;
    logic [15:0] raw;
    logic [15:0] scaled;
    logic [15:0] avg;
  } res_t;

  function automatic logic [GAIN_W-1:0] gain_of(input logic [15:0] raw);
    logic [GAIN_W-1:0] g;
    g = GAIN_HUND[GAIN_SEGMENTS-1];
    for (int i = GAIN_SEGMENTS - 2; i >= 0; i--) begin
      if (raw <= GAIN_LIMIT[i]) g = GAIN_HUND[i];
    end
    return g;
  endfunction

endpackage

// ===== design/dsfa_front.sv =====
`timescale 1ns / 1ps
module dsfa_front import dsfa_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_push,
  output logic       in_full,
  input  logic [7:0] in_rx_byte,
  output logic       job_push,
  output job_t       job,
  input  logic       job_full
);

  fpos_t       pos_r, pos_nxt;
  logic        accept;
  logic [7:0]  vhi_r, vlo_r, csum_r, chk_r;

  assign in_full = job_full;
  assign accept  = in_push && !job_full;

  always_comb begin
    pos_nxt = pos_r;
    case (pos_r)
      FP_HUNT: if (accept && in_rx_byte == HEADER_BYTE) pos_nxt = FP_VHI;
      FP_VHI:  if (accept) pos_nxt = FP_VLO;
      FP_VLO:  if (accept) pos_nxt = FP_RHI;
      FP_RHI:  if (accept) pos_nxt = FP_RLO;
      FP_RLO:  if (accept) pos_nxt = FP_CSUM;
      FP_CSUM: if (accept) pos_nxt = FP_END;
      FP_END:  if (accept) pos_nxt = FP_HUNT;
      default: pos_nxt = FP_HUNT;
    endcase
  end

  // The frame is classified as its end byte arrives.
  always_comb begin
    job_push   = 1'b0;
    job.raw    = {vhi_r, vlo_r};
    job.status = ST_STORED;
    case (pos_r)
      FP_END: begin
        job_push = accept;
        if (csum_r != chk_r || in_rx_byte != END_BYTE) begin
          job.status = ST_BAD;
        end else if ({vhi_r, vlo_r} == 16'd0) begin
          job.status = ST_ZERO;
        end
      end
      default: job_push = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= FP_HUNT;
    end else begin
      pos_r <= pos_nxt;
    end
  end

  // Data bytes and the running 8-bit checksum of them.
  always_ff @(posedge clk) begin
    if (accept) begin
      case (pos_r)
        FP_VHI: begin
          vhi_r  <= in_rx_byte;
          csum_r <= in_rx_byte;
        end
        FP_VLO: begin
          vlo_r  <= in_rx_byte;
          csum_r <= csum_r + in_rx_byte;
        end
        FP_RHI:  csum_r <= csum_r + in_rx_byte;
        FP_RLO:  csum_r <= csum_r + in_rx_byte;
        FP_CSUM: chk_r  <= in_rx_byte;
        default: chk_r  <= chk_r;
      endcase
    end
  end

endmodule

// ===== design/dsfa_jobq.sv =====
`timescale 1ns / 1ps
module dsfa_jobq import dsfa_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_job,
  output logic full,
  input  logic pop,
  output job_t head,
  output logic empty
);

  localparam int AW = $clog2(JOBQ_DEPTH);
  localparam int CW = $clog2(JOBQ_DEPTH + 1);

  job_t          mem_r [JOBQ_DEPTH];
  logic [AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] count_r;
  logic          do_push, do_pop;

  assign full    = (count_r == CW'(JOBQ_DEPTH));
  assign empty   = (count_r == '0);
  assign head    = mem_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= push_job;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == AW'(JOBQ_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == AW'(JOBQ_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) count_r <= count_r + 1'b1;
      else if (do_pop && !do_push) count_r <= count_r - 1'b1;
    end
  end

endmodule

// ===== design/dsfa_back.sv =====
`timescale 1ns / 1ps
module dsfa_back import dsfa_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  job_t        job_head,
  input  logic        job_empty,
  output logic        job_pop,
  output logic        out_empty,
  input  logic        out_pop,
  output res_t        out_res
);

  localparam int OAW = $clog2(OUTQ_DEPTH);
  localparam int OCW = $clog2(OUTQ_DEPTH + 1) + 1;

  // Ring storage and the pointer into it.
  logic [15:0]         ring_mem [RING_DEPTH];
  logic [RING_AW-1:0]  wp_r;
  logic                wrapped_r;
  logic [15:0]         rd_data_r;
  logic                issue_store;

  // Stage 1: gain product, ring entry being read.
  logic                s1_v_r, s1_fresh_r;
  job_t                s1_job_r;
  logic [PROD_W-1:0]   s1_prod_r;
  logic [RING_AW-1:0]  s1_wp_r;
  logic [GAIN_W+15:0]  gain_prod;

  // Stage 2: scaled value and the entry it replaces.
  logic                s2_v_r;
  job_t                s2_job_r;
  logic [15:0]         s2_scaled_r, s2_old_r;
  logic [RING_AW-1:0]  s2_wp_r;
  logic [PROD_W+RECIP_W-1:0] recip_prod;

  // Running sum and result queue.
  logic [SUM_W-1:0]    sum_r, sum_nxt;
  res_t                res;
  res_t                outq_r [OUTQ_DEPTH];
  logic [OAW-1:0]      owr_r, ord_r;
  logic [OCW-1:0]      ocount_r;
  logic                o_pop;

  // A job starts only when the result queue has room for it and for
  // everything already in flight, so the stages never stall.
  assign job_pop = !job_empty &&
                   ((ocount_r + OCW'(s1_v_r) + OCW'(s2_v_r)) < OCW'(OUTQ_DEPTH));
  assign issue_store = job_pop && (job_head.status == ST_STORED);
  assign gain_prod   = job_head.raw * gain_of(job_head.raw);
  assign recip_prod  = s1_prod_r * RECIP_100;

  always_ff @(posedge clk) begin
    rd_data_r   <= ring_mem[wp_r];
    s1_job_r    <= job_head;
    s1_prod_r   <= gain_prod[PROD_W-1:0];
    s1_wp_r     <= wp_r;
    s1_fresh_r  <= !wrapped_r;
    s2_job_r    <= s1_job_r;
    s2_wp_r     <= s1_wp_r;
    s2_scaled_r <= (s1_job_r.status == ST_STORED) ?
                   recip_prod[RECIP_SHIFT +: 16] : 16'd0;
    s2_old_r    <= s1_fresh_r ? 16'(RESET_FILL) : rd_data_r;
  end

  always_ff @(posedge clk) begin
    if (s2_v_r && s2_job_r.status == ST_STORED) ring_mem[s2_wp_r] <= s2_scaled_r;
  end

  always_comb begin
    sum_nxt = sum_r;
    if (s2_v_r && s2_job_r.status == ST_STORED) begin
      sum_nxt = sum_r - SUM_W'(s2_old_r) + SUM_W'(s2_scaled_r);
    end
    res.status = s2_job_r.status;
    res.raw    = s2_job_r.raw;
    res.scaled = s2_scaled_r;
    res.avg    = sum_nxt[RING_AW +: 16];
  end

  assign out_empty = (ocount_r == '0);
  assign out_res   = outq_r[ord_r];
  assign o_pop     = out_pop && !out_empty;

  always_ff @(posedge clk) begin
    if (s2_v_r) outq_r[owr_r] <= res;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r      <= '0;
      wrapped_r <= 1'b0;
      s1_v_r    <= 1'b0;
      s2_v_r    <= 1'b0;
      sum_r     <= SUM_W'(RING_DEPTH * RESET_FILL);
      owr_r     <= '0;
      ord_r     <= '0;
      ocount_r  <= '0;
    end else begin
      s1_v_r <= job_pop;
      s2_v_r <= s1_v_r;
      sum_r  <= sum_nxt;
      if (issue_store) begin
        wp_r <= (wp_r == RING_AW'(RING_DEPTH - 1)) ? '0 : wp_r + 1'b1;
        if (wp_r == RING_AW'(RING_DEPTH - 1)) wrapped_r <= 1'b1;
      end
      if (s2_v_r) begin
        owr_r <= (owr_r == OAW'(OUTQ_DEPTH - 1)) ? '0 : owr_r + 1'b1;
      end
      if (o_pop) begin
        ord_r <= (ord_r == OAW'(OUTQ_DEPTH - 1)) ? '0 : ord_r + 1'b1;
      end
      if (s2_v_r && !o_pop) ocount_r <= ocount_r + 1'b1;
      else if (o_pop && !s2_v_r) ocount_r <= ocount_r - 1'b1;
    end
  end

endmodule

// ===== design/dust_sensor_frame_average_unit.sv =====
`timescale 1ns / 1ps
// Dust sensor frame average unit.
// Input channel: one serial byte per transaction on in_rx_byte, taken when
// in_push is high and in_full is low. A byte can be taken in every cycle.
// The parser hunts for a 0xAA header, collects four data bytes and a checksum,
// and classifies the frame when its end byte arrives.
// Result channel: one transaction per end byte. While out_empty is low the
// oldest result sits on the out_ ports and leaves on a cycle with out_pop high.
// The gain multiply, the divide by 100 and the ring update are the three stages
// of the back part, which takes one frame each cycle while the result queue has
// room; the result is written to that queue with the ring update.
// The front part and the back part are joined by a two-entry job queue, and
// the back part holds up to four finished results. When the receiver stalls,
// results pile up there, then jobs wait, and only then does in_full rise.
// Reset clears the parser to hunting, the ring pointer to zero and the running
// sum to 512 times 35. Ring entries are not cleared: until the pointer first
// wraps, an entry about to be overwritten counts as 35. No clearing pass runs.
module dust_sensor_frame_average_unit import dsfa_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic [7:0]  in_rx_byte,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [1:0]  out_frame_status,
  output logic [15:0] out_raw_value,
  output logic [15:0] out_scaled_value,
  output logic [15:0] out_average_value
);

`include "dust_sensor_frame_average_unit_macros.svh"

  job_t jq_in_job, jq_head;
  logic jq_push, jq_full, jq_pop, jq_empty;
  res_t out_res;

  dsfa_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_push    (in_push),
    .in_full    (in_full),
    .in_rx_byte (in_rx_byte),
    .job_push   (jq_push),
    .job        (jq_in_job),
    .job_full   (jq_full)
  );

  dsfa_jobq u_jobq (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (jq_push),
    .push_job (jq_in_job),
    .full     (jq_full),
    .pop      (jq_pop),
    .head     (jq_head),
    .empty    (jq_empty)
  );

  dsfa_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_head  (jq_head),
    .job_empty (jq_empty),
    .job_pop   (jq_pop),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_res   (out_res)
  );

  assign out_frame_status  = out_res.status;
  assign out_raw_value     = out_res.raw;
  assign out_scaled_value  = out_res.scaled;
  assign out_average_value = out_res.avg;

  // A frame that was not stored never reports a scaled value.
  `DSFA_ASSERT_NOW(a_unstored_scaled_zero, !out_empty && out_frame_status != ST_STORED, out_scaled_value == 16'd0, "scaled value on an unstored frame")
  // The zero-skip status goes with a zero raw value and only with it.
  `DSFA_ASSERT_NOW(a_zero_status_raw, !out_empty && out_frame_status == ST_ZERO, out_raw_value == 16'd0, "zero status with nonzero raw value")
  `DSFA_ASSERT_NOW(a_stored_raw_nonzero, !out_empty && out_frame_status == ST_STORED, out_raw_value != 16'd0, "stored frame with zero raw value")
  // A full job queue that the back part does not drain keeps the input held off.
  `DSFA_ASSERT_NEXT(a_full_holds, jq_full && !jq_pop, in_full, "input released with a full job queue")

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
import dsfa_pkg::*;

// Tracks the frame parser, the piecewise gain and the sample ring, and holds
// the frame results that the unit still owes.
class frame_average_tracker;
  fpos_t                position;
  logic [7:0]           frame_bytes [5];
  logic [15:0]          ring [RING_DEPTH];
  logic [RING_AW-1:0]   ring_ptr;
  logic [SUM_W-1:0]     ring_sum;
  res_t                 owed_frames [$];
  int unsigned          errors;

  function new();
    position = FP_HUNT;
    foreach (frame_bytes[i]) frame_bytes[i] = 8'h00;
    foreach (ring[i]) ring[i] = 16'(RESET_FILL);
    ring_ptr = '0;
    ring_sum = SUM_W'(RING_DEPTH * RESET_FILL);
    errors = 0;
  endfunction

  // Gain in hundredths, one step per raw threshold.
  function int unsigned gain_for(logic [15:0] r);
    if (r <= 1) return 3500;
    if (r <= 2) return 2000;
    if (r <= 3) return 1500;
    if (r <= 4) return 1125;
    if (r <= 6) return 1000;
    if (r <= 8) return 760;
    if (r <= 10) return 650;
    if (r <= 12) return 625;
    if (r <= 15) return 620;
    if (r <= 19) return 562;
    if (r <= 25) return 500;
    if (r <= 35) return 488;
    if (r <= 50) return 450;
    if (r <= 75) return 329;
    if (r <= 100) return 250;
    if (r <= 150) return 167;
    if (r <= 285) return 100;
    if (r <= 485) return 70;
    return 60;
  endfunction

  // Called for every byte the unit accepts.
  function void take_byte(logic [7:0] b);
    res_t        r;
    logic [7:0]  sum8;
    int unsigned product;
    case (position)
      FP_HUNT: begin
        position = (b == HEADER_BYTE) ? FP_VHI : FP_HUNT;
      end
      FP_END: begin
        position = FP_HUNT;
        r.raw = {frame_bytes[0], frame_bytes[1]};
        r.scaled = 16'h0000;
        sum8 = frame_bytes[0] + frame_bytes[1] + frame_bytes[2] + frame_bytes[3];
        if (sum8 != frame_bytes[4] || b != END_BYTE) begin
          r.status = ST_BAD;
        end else if (r.raw == 16'h0000) begin
          r.status = ST_ZERO;
        end else begin
          r.status = ST_STORED;
          product = r.raw * gain_for(r.raw);
          r.scaled = 16'(product / 100);
          ring_sum = ring_sum - ring[ring_ptr] + r.scaled;
          ring[ring_ptr] = r.scaled;
          ring_ptr = ring_ptr + 1'b1;
        end
        r.avg = 16'(ring_sum / RING_DEPTH);
        owed_frames.push_back(r);
      end
      default: begin
        frame_bytes[position - 1] = b;
        position = fpos_t'(position + 1);
      end
    endcase
  endfunction

  // Called for every result the unit hands over.
  function void check_frame(res_t got);
    res_t want;
    if (owed_frames.size() == 0) begin
      $error("unexpected frame result: status %0d raw %0d", got.status, got.raw);
      errors++;
      return;
    end
    want = owed_frames.pop_front();
    if (got.status !== want.status) begin
      $error("frame_status mismatch: expected %0d, actual %0d", want.status, got.status);
      errors++;
    end
    if (got.raw !== want.raw) begin
      $error("raw_value mismatch: expected %0d, actual %0d", want.raw, got.raw);
      errors++;
    end
    if (got.scaled !== want.scaled) begin
      $error("scaled_value mismatch: expected %0d, actual %0d", want.scaled, got.scaled);
      errors++;
    end
    if (got.avg !== want.avg) begin
      $error("average_value mismatch: expected %0d, actual %0d", want.avg, got.avg);
      errors++;
    end
  endfunction
endclass

module tb_top;

  // Number of random bytes, counted at the input handshake.
  localparam int RANDOM_BYTES = 850;
  // Past this many random bytes both sides stop idling so the tail runs at
  // full rate.
  localparam int CALM_AFTER = 700;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_push = 1'b0;
  logic        in_full;
  logic [7:0]  in_rx_byte = 8'h00;
  logic        out_empty;
  logic        out_pop = 1'b0;
  logic [1:0]  out_frame_status;
  logic [15:0] out_raw_value;
  logic [15:0] out_scaled_value;
  logic [15:0] out_average_value;

  frame_average_tracker tracker = new();
  bit          calm = 1'b0;
  int          bytes_sent = 0;

  dust_sensor_frame_average_unit dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_push           (in_push),
    .in_full           (in_full),
    .in_rx_byte        (in_rx_byte),
    .out_empty         (out_empty),
    .out_pop           (out_pop),
    .out_frame_status  (out_frame_status),
    .out_raw_value     (out_raw_value),
    .out_scaled_value  (out_scaled_value),
    .out_average_value (out_average_value)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Moves one byte across the input handshake. An idle burst, when one is
  // drawn, comes before the byte is offered, so push is never dropped and
  // raised in the same step. The byte is handed to the tracker at the edge
  // that accepts it.
  task automatic send_byte(input logic [7:0] b);
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_push <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_push <= 1'b1;
    in_rx_byte <= b;
    @(posedge clk);
    while (in_full) @(posedge clk);
    tracker.take_byte(b);
    bytes_sent++;
  endtask

  // Sends a complete frame. The checksum is made wrong on request by flipping
  // a nonzero pattern of its bits.
  task automatic send_frame(input logic [15:0] raw, input logic [15:0] ref_word,
                            input bit bad_sum, input logic [7:0] end_b);
    logic [7:0] csum;
    csum = raw[15:8] + raw[7:0] + ref_word[15:8] + ref_word[7:0];
    if (bad_sum) csum = csum ^ 8'($urandom_range(1, 255));
    send_byte(HEADER_BYTE);
    send_byte(raw[15:8]);
    send_byte(raw[7:0]);
    send_byte(ref_word[15:8]);
    send_byte(ref_word[7:0]);
    send_byte(csum);
    send_byte(end_b);
  endtask

  // Raw values lean toward the gain thresholds, where the segment choice is
  // easiest to get wrong, and toward both ends of the range.
  function automatic logic [15:0] pick_raw();
    int unsigned sel;
    int          edge_at;
    sel = $urandom_range(0, 9);
    if (sel == 0) return 16'h0000;
    if (sel <= 4) begin
      edge_at = int'(GAIN_LIMIT[$urandom_range(0, GAIN_SEGMENTS - 2)]);
      edge_at = edge_at + int'($urandom_range(0, 2)) - 1;
      return 16'(edge_at);
    end
    if (sel <= 6) return 16'($urandom_range(1, 600));
    if (sel <= 8) return 16'($urandom);
    return 16'hFFFF - 16'($urandom_range(0, 3));
  endfunction

  // Result side: a transaction is taken at every edge with pop high and
  // empty low. Pop is decided once per step, with random stall bursts until
  // the calm tail of the run.
  initial begin
    int   stall_left;
    res_t got;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_pop && !out_empty) begin
        got.status = status_t'(out_frame_status);
        got.raw = out_raw_value;
        got.scaled = out_scaled_value;
        got.avg = out_average_value;
        tracker.check_frame(got);
      end
      if (stall_left > 0) begin
        out_pop <= 1'b0;
        stall_left--;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        out_pop <= 1'b0;
        stall_left = $urandom_range(1, 8) - 1;
      end else begin
        out_pop <= 1'b1;
      end
    end
  end

  // Stimulus and end of run.
  initial begin
    int          kind;
    int          random_start;
    logic [15:0] ref_word;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part. A stray byte while hunting must be ignored. The first
    // frame carries the largest raw value and a header byte inside its data.
    // Then a zero value, a bad checksum, and a bad end byte that is itself a
    // header byte: the parser must not treat it as the start of a new frame.
    send_byte(8'h55);
    send_frame(16'hFFFF, 16'hAA00, 1'b0, END_BYTE);
    send_frame(16'h0000, 16'h1234, 1'b0, END_BYTE);
    send_frame(16'h0001, 16'h00FF, 1'b1, END_BYTE);
    send_frame(16'h0102, 16'h0000, 1'b0, HEADER_BYTE);

    // Random part. Most of it is well-formed frames with random content;
    // the rest is line noise and frames cut short, after which the parser
    // swallows whatever follows as frame data.
    random_start = bytes_sent;
    while (bytes_sent - random_start < RANDOM_BYTES) begin
      if (bytes_sent - random_start > CALM_AFTER) calm = 1'b1;
      kind = $urandom_range(0, 9);
      if (kind == 0) begin
        repeat ($urandom_range(1, 4)) send_byte(8'($urandom));
      end else if (kind == 1) begin
        send_byte(HEADER_BYTE);
        repeat ($urandom_range(1, 5)) send_byte(8'($urandom));
      end else begin
        ref_word = 16'($urandom);
        send_frame(pick_raw(), ref_word, $urandom_range(0, 6) == 0,
                   ($urandom_range(0, 9) == 0) ? 8'($urandom) : END_BYTE);
      end
    end
    calm = 1'b1;
    in_push <= 1'b0;

    // Drain: every owed result must arrive, and nothing may follow it.
    while (tracker.owed_frames.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
    if (tracker.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest legal run.
  initial begin
    #2000000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
